[hdl/cdq_pkg.sv]
// Shared types and constants for the circular deque.
package cdq_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEPTH_DEFAULT      = 8;
    localparam int WORD_WIDTH_DEFAULT = 32;

    // Field widths of the request and response words.
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // Request kinds; the two remaining codes are ignored.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Request word.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Response word.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    // Operation applied to every cell of one chain in a cycle. The near end is
    // cell 0, the far end is the last cell.
    typedef struct packed {
        logic shift_up;    // insert at the near end, everything moves outwards
        logic shift_down;  // remove at the near end, everything moves inwards
        logic load_end;    // append behind the last held word
        logic drop_end;    // remove the last held word
    } chain_op_t;

endpackage

[hdl/cdq_cell.sv]
// One storage cell of a deque chain: a word, its valid flag and neighbour links.
module cdq_cell #(
    parameter int WORD_WIDTH = cdq_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_pkg::chain_op_t    op,
    input  logic [WORD_WIDTH-1:0] new_word,
    input  logic [WORD_WIDTH-1:0] below_word,
    input  logic                  below_valid,
    input  logic [WORD_WIDTH-1:0] above_word,
    input  logic                  above_valid,
    output logic [WORD_WIDTH-1:0] word,
    output logic                  valid
);
    import cdq_pkg::*;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  valid_reg;
    logic                  valid_next;

    // Local decision: take from a neighbour, load a new word or drop the word.
    always_comb
    begin
        word_next  = word_reg;
        valid_next = valid_reg;
        priority if (op.shift_up)
        begin
            word_next  = below_word;
            valid_next = below_valid;
        end
        else if (op.shift_down)
        begin
            word_next  = above_word;
            valid_next = above_valid;
        end
        else if (op.load_end)
        begin
            if (!valid_reg && below_valid)
            begin
                word_next  = new_word;
                valid_next = 1'b1;
            end
        end
        else if (op.drop_end)
        begin
            if (valid_reg && !above_valid)
            begin
                valid_next = 1'b0;
            end
        end
        else
        begin
            // No operation this cycle: the cell keeps its word.
            word_next  = word_reg;
            valid_next = valid_reg;
        end
    end

    // The valid flag is control state; the word itself needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign valid = valid_reg;

endmodule

[hdl/cdq_chain.sv]
// A row of deque cells with the held words packed against the near end.
module cdq_chain #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = cdq_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_pkg::chain_op_t    op,
    input  logic [WORD_WIDTH-1:0] new_word,
    output logic [WORD_WIDTH-1:0] near_word,
    output logic                  near_valid,
    output logic                  far_valid
);
    import cdq_pkg::*;

    logic [WORD_WIDTH-1:0] words [DEPTH];
    logic [DEPTH-1:0]      valids;

    // Each cell sees its two neighbours; the ends see the new word and an empty slot.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] below_word;
        logic                  below_valid;
        logic [WORD_WIDTH-1:0] above_word;
        logic                  above_valid;

        if (i == 0)
        begin : g_near
            assign below_word  = new_word;
            assign below_valid = 1'b1;
        end
        else
        begin : g_inner_below
            assign below_word  = words[i-1];
            assign below_valid = valids[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_far
            assign above_word  = '0;
            assign above_valid = 1'b0;
        end
        else
        begin : g_inner_above
            assign above_word  = words[i+1];
            assign above_valid = valids[i+1];
        end

        cdq_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .new_word    (new_word),
            .below_word  (below_word),
            .below_valid (below_valid),
            .above_word  (above_word),
            .above_valid (above_valid),
            .word        (words[i]),
            .valid       (valids[i])
        );
    end

    assign near_word  = words[0];
    assign near_valid = valids[0];
    assign far_valid  = valids[DEPTH-1];

endmodule

[hdl/circular_deque.sv]
// Top level of the circular deque: request decode, occupancy and response register.
//
// Usage: a request word (kind, value) is taken at a rising edge where start is
// high and busy is low. busy stays low, so a request may be given every cycle.
// Each request yields exactly one response word (data, status, occupancy),
// shown on rsp for one cycle with done high, in the cycle after the request
// was taken. The receiver cannot stall; it must take the word in that cycle.
// The throughput is one request per cycle, as the two cell chains and the count
// register are all updated at the edge that takes each request.
// Storage is two mirrored rows of DEPTH cells: one keeps the front word in its
// first cell, the other keeps the back word in its first cell, so both ends
// are read without any search. Pushes to a full deque return status full, and
// pops or peeks on an empty deque return status empty; neither changes state.
// Reset empties the deque at once (all valid flags and the count cleared) and
// removes any pending response; stored words are not cleared.
module circular_deque #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = cdq_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cdq_pkg::req_t req,
    output logic          done,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [WORD_WIDTH-1:0] push_word;
    logic [63:0]           value_ext;
    logic [63:0]           data_ext;
    logic [63:0]           count_ext;
    chain_op_t             front_op;
    chain_op_t             back_op;
    logic [WORD_WIDTH-1:0] front_word;
    logic                  front_valid;
    logic                  front_far_valid;
    logic [WORD_WIDTH-1:0] back_word;
    logic                  back_valid;
    logic                  back_far_valid;
    logic [WORD_WIDTH-1:0] read_word;
    logic                  read_ok;
    logic [STATUS_W-1:0]   status_now;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    logic                  done_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Both chains hold the same words, so either can report empty and full.
    assign is_empty = !front_valid;
    assign is_full  = front_far_valid;

    // Keep the low bits of the pushed value.
    assign value_ext = {32'd0, req.value};
    assign push_word = value_ext[WORD_WIDTH-1:0];

    // Decode the request into chain operations, count update and response.
    always_comb
    begin
        front_op   = '0;
        back_op    = '0;
        count_next = count_reg;
        status_now = STATUS_OK;
        read_ok    = 1'b0;
        read_word  = front_word;
        if (accept)
        begin
            unique case (req.kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_now = STATUS_FULL;
                    end
                    else
                    begin
                        if (req.kind == KIND_PUSH_FRONT)
                        begin
                            front_op.shift_up = 1'b1;
                            back_op.load_end  = 1'b1;
                        end
                        else
                        begin
                            front_op.load_end = 1'b1;
                            back_op.shift_up  = 1'b1;
                        end
                        count_next = count_reg + CNT_ONE;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_now = STATUS_EMPTY;
                    end
                    else
                    begin
                        read_ok = 1'b1;
                        if (req.kind == KIND_POP_FRONT || req.kind == KIND_PEEK_FRONT)
                        begin
                            read_word = front_word;
                        end
                        else
                        begin
                            read_word = back_word;
                        end
                        if (req.kind == KIND_POP_FRONT)
                        begin
                            front_op.shift_down = 1'b1;
                            back_op.drop_end    = 1'b1;
                            count_next          = count_reg - CNT_ONE;
                        end
                        else if (req.kind == KIND_POP_BACK)
                        begin
                            front_op.drop_end  = 1'b1;
                            back_op.shift_down = 1'b1;
                            count_next         = count_reg - CNT_ONE;
                        end
                    end
                end
                default:
                begin
                    status_now = STATUS_OK;
                end
            endcase
        end
    end

    // Assemble the response word.
    assign data_ext  = read_ok ? {{(64 - WORD_WIDTH){1'b0}}, read_word} : 64'd0;
    assign count_ext = 64'(count_next);

    always_comb
    begin
        rsp_next.data      = data_ext[DATA_W-1:0];
        rsp_next.status    = status_now;
        rsp_next.occupancy = count_ext[OCC_W-1:0];
        done_next          = accept;
    end

    // Chain with the front word in its first cell.
    cdq_chain #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (front_op),
        .new_word   (push_word),
        .near_word  (front_word),
        .near_valid (front_valid),
        .far_valid  (front_far_valid)
    );

    // Chain with the back word in its first cell.
    cdq_chain #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (back_op),
        .new_word   (push_word),
        .near_word  (back_word),
        .near_valid (back_valid),
        .far_valid  (back_far_valid)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // The two chains must agree on whether the deque is empty or full.
    a_chains_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid == back_valid) && (front_far_valid == back_far_valid))
        else $error("front and back chains disagree on empty or full");

    // The count is zero exactly when the chains hold nothing, and DEPTH when full.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == '0) == !front_valid) && ((count_reg == CNT_FULL) == front_far_valid))
        else $error("occupancy count out of step with the cell chains");

    // Every accepted request gives a response in the next cycle.
    a_one_response: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted request produced no response");

    // A refused request leaves the occupancy unchanged.
    a_refusal_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_OK) |-> $stable(count_reg))
        else $error("refused request changed the occupancy");
`endif

endmodule
